// File: rtl/hfmc_pkg.sv
// hfmc_pkg: shared types, register codes and helper functions for the
// heater/fan mode controller. No dependencies.
package hfmc_pkg;

  localparam int unsigned NUM_FN     = 3;
  localparam int unsigned FN_HEATER  = 0;
  localparam int unsigned FN_LAMP    = 1;
  localparam int unsigned FN_FAN     = 2;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned SUM_W      = 11;

  localparam logic [8:0] TEMP_OFFSET = 9'd50;
  localparam logic [8:0] TEMP_MAX    = 9'd255;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_ADC    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEATER_TIMEOUT = 4'd0,
    CFG_FAN_TIMEOUT    = 4'd1,
    CFG_LAMP_TIMEOUT   = 4'd2,
    CFG_SENSOR_PERIOD  = 4'd3,
    CFG_SETPOINT_LOW   = 4'd4,
    CFG_SETPOINT_MID   = 4'd5,
    CFG_SETPOINT_HIGH  = 4'd6,
    CFG_CRITICAL_LIMIT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] heater_timeout;
    logic [31:0] fan_timeout;
    logic [31:0] lamp_timeout;
    logic [31:0] sensor_period;
    logic [7:0]  setpoint_low;
    logic [7:0]  setpoint_mid;
    logic [7:0]  setpoint_high;
    logic [7:0]  critical_limit;
  } cfg_t;

  // Per-function mode state, indexed heater/lamp/fan; restart flags live for one item.
  typedef struct packed {
    logic [NUM_FN-1:0][2:0] cnt;
    logic [NUM_FN-1:0][2:0] acted;
    logic [NUM_FN-1:0]      last;
    logic [1:0]             heater_lvl;
    logic [1:0]             fan_lvl;
    logic                   heater_lamp;
    logic                   fan_lamp;
    logic                   signal_lamp;
    logic [NUM_FN-1:0]      restart;
  } mode_t;

  typedef struct packed {
    logic [1:0] heater_drive;
    logic [7:0] heater_compare;
    logic [1:0] fan_drive;
    logic [4:0] fan_compare;
    logic       heater_lamp;
    logic       fan_lamp;
    logic       signal_lamp;
    logic       check_pending;
    logic [2:0] heater_mode;
    logic [2:0] fan_mode;
    logic [1:0] lamp_mode;
  } res_t;

  function automatic logic [2:0] mode_limit(int unsigned f);
    logic [2:0] lim;
    lim = (f == FN_LAMP) ? 3'd2 : 3'd4;
    return lim;
  endfunction

  function automatic logic [7:0] heat_cmp(logic [1:0] lvl);
    logic [7:0] v;
    case (lvl)
      2'd1:    v = 8'd51;
      2'd2:    v = 8'd102;
      2'd3:    v = 8'd153;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] fan_cmp(logic [1:0] lvl);
    logic [4:0] v;
    case (lvl)
      2'd1:    v = 5'd6;
      2'd2:    v = 5'd13;
      2'd3:    v = 5'd20;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic mode_t apply_mode(mode_t s, int unsigned f, logic [2:0] m);
    mode_t      r;
    logic [1:0] lvl;
    r   = s;
    lvl = (m >= 3'd1 && m <= 3'd3) ? m[1:0] : 2'd0;
    if (f == FN_HEATER) begin
      r.heater_lvl  = lvl;
      r.heater_lamp = (lvl != 2'd0);
    end else if (f == FN_FAN) begin
      r.fan_lvl  = lvl;
      r.fan_lamp = (lvl != 2'd0);
    end else begin
      r.signal_lamp = (m == 3'd1);
    end
    return r;
  endfunction

  function automatic mode_t switch_step(mode_t s, int unsigned f, logic level);
    mode_t       r;
    int unsigned g;
    r = s;
    if (level != r.last[f]) begin
      r.last[f] = level;
      r.cnt[f]  = r.cnt[f] + 3'd1;
    end
    if (r.cnt[f] > mode_limit(f)) begin
      r.cnt[f] = 3'd1;
    end
    if (r.cnt[f] != r.acted[f]) begin
      for (g = 0; g < NUM_FN; g++) begin
        if (g != f) begin
          r          = apply_mode(r, g, 3'd0);
          r.cnt[g]   = 3'd0;
          r.acted[g] = 3'd0;
        end
      end
      r.restart[f] = 1'b1;
      r.acted[f]   = r.cnt[f];
      r            = apply_mode(r, f, r.cnt[f]);
    end
    return r;
  endfunction

  // A function restarted by this item has zero elapsed time.
  function automatic mode_t timeout_step(mode_t s, int unsigned f, logic expired);
    mode_t r;
    r = s;
    if (expired && !r.restart[f]) begin
      r          = apply_mode(r, f, 3'd0);
      r.cnt[f]   = 3'd0;
      r.acted[f] = 3'd0;
    end
    return r;
  endfunction

  function automatic mode_t thermostat(mode_t s, logic [SUM_W-1:0] avg, cfg_t c);
    mode_t      r;
    logic [2:0] m;
    logic [7:0] sp;
    logic       on;
    r  = s;
    m  = s.acted[FN_HEATER];
    sp = (m == 3'd1) ? c.setpoint_low : (m == 3'd2) ? c.setpoint_mid : c.setpoint_high;
    on = (avg < {3'b000, c.critical_limit}) && (m >= 3'd1) && (m <= 3'd3)
         && (avg < {3'b000, sp});
    r  = apply_mode(r, FN_HEATER, on ? m : 3'd0);
    return r;
  endfunction

endpackage

// File: rtl/hfmc_cfg.sv
// hfmc_cfg: configuration register file with reset defaults.
// Depends on hfmc_pkg.
module hfmc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_i,
  input  logic [hfmc_pkg::CFG_IDX_W-1:0]       index_i,
  input  logic [hfmc_pkg::CFG_DATA_W-1:0]      data_i,
  output hfmc_pkg::cfg_t                       cfg_o
);
  import hfmc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heater_timeout <= 32'd50000;
      cfg_q.fan_timeout    <= 32'd30000;
      cfg_q.lamp_timeout   <= 32'd30000;
      cfg_q.sensor_period  <= 32'd5000;
      cfg_q.setpoint_low   <= 8'd30;
      cfg_q.setpoint_mid   <= 8'd50;
      cfg_q.setpoint_high  <= 8'd70;
      cfg_q.critical_limit <= 8'd80;
    end else if (wr_i) begin
      case (index_i)
        CFG_HEATER_TIMEOUT: cfg_q.heater_timeout <= data_i;
        CFG_FAN_TIMEOUT:    cfg_q.fan_timeout    <= data_i;
        CFG_LAMP_TIMEOUT:   cfg_q.lamp_timeout   <= data_i;
        CFG_SENSOR_PERIOD:  cfg_q.sensor_period  <= data_i;
        CFG_SETPOINT_LOW:   cfg_q.setpoint_low   <= data_i[7:0];
        CFG_SETPOINT_MID:   cfg_q.setpoint_mid   <= data_i[7:0];
        CFG_SETPOINT_HIGH:  cfg_q.setpoint_high  <= data_i[7:0];
        CFG_CRITICAL_LIMIT: cfg_q.critical_limit <= data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/hfmc_core.sv
// hfmc_core: controller state and single-pass update for one item
// (timers, switch modes, timeouts, ADC averaging, thermostat). Depends on hfmc_pkg.
module hfmc_core #(
  parameter int unsigned SAMPLES_PER_CHECK = 5,
  parameter int unsigned TIME_BITS         = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [1:0]                      op_i,
  input  logic                            heater_switch_i,
  input  logic                            lamp_switch_i,
  input  logic                            fan_switch_i,
  input  logic [hfmc_pkg::ADC_W-1:0]      adc_value_i,
  input  hfmc_pkg::cfg_t                  cfg_i,
  output hfmc_pkg::res_t                  res_o
);
  import hfmc_pkg::*;

  localparam int unsigned CntW       = (SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 1;
  localparam int unsigned ElapW      = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned ProdW      = SUM_W + RecipShift + 1;
  localparam int unsigned RecipVal   =
    ((1 << RecipShift) + SAMPLES_PER_CHECK - 1) / SAMPLES_PER_CHECK;

  logic [31:0]                        phase_q, phase_d, phase_inc;
  logic [NUM_FN-1:0][TIME_BITS-1:0]   elapsed_q, elapsed_d, elapsed_inc;
  logic [NUM_FN-1:0][31:0]            limit;
  logic [NUM_FN-1:0]                  expired;
  mode_t                              mode_q, mode_d;
  mode_t                              m0, m1, m2, m3, m4, m5, m6;
  logic [CntW-1:0]                    cnt_q, cnt_d;
  logic [SUM_W-1:0]                   sum_q, sum_d, sum_add, avg;
  logic                               check_q, check_d;
  logic                               is_tick, is_switch, is_adc, period_hit;
  logic [18:0]                        scaled;
  logic [8:0]                         deg_raw, deg_off;
  logic [TEMP_W-1:0]                  temp;
  logic                               take, last_sample;
  logic [ProdW-1:0]                   prod;

  assign is_tick   = (op_i == OP_TICK);
  assign is_switch = (op_i == OP_SWITCH);
  assign is_adc    = (op_i == OP_ADC);

  // sensor period
  assign phase_inc  = phase_q + 32'd1;
  assign period_hit = (phase_inc >= cfg_i.sensor_period);
  assign phase_d    = is_tick ? (period_hit ? 32'd0 : phase_inc) : phase_q;

  // elapsed time per function, wrapping at TIME_BITS bits
  assign limit[FN_HEATER] = cfg_i.heater_timeout;
  assign limit[FN_LAMP]   = cfg_i.lamp_timeout;
  assign limit[FN_FAN]    = cfg_i.fan_timeout;

  always_comb begin
    for (int unsigned f = 0; f < NUM_FN; f++) begin
      elapsed_inc[f] = elapsed_q[f] + TIME_BITS'(is_tick);
      expired[f]     = ElapW'(elapsed_inc[f]) > ElapW'(limit[f]);
    end
  end

  // mode chain: heater, lamp, fan, each switch then timeout
  always_comb begin
    m0         = mode_q;
    m0.restart = '0;
    m1 = is_switch ? switch_step(m0, FN_HEATER, heater_switch_i) : m0;
    m2 = timeout_step(m1, FN_HEATER, expired[FN_HEATER]);
    m3 = is_switch ? switch_step(m2, FN_LAMP, lamp_switch_i) : m2;
    m4 = timeout_step(m3, FN_LAMP, expired[FN_LAMP]);
    m5 = is_switch ? switch_step(m4, FN_FAN, fan_switch_i) : m4;
    m6 = timeout_step(m5, FN_FAN, expired[FN_FAN]);
  end

  always_comb begin
    for (int unsigned f = 0; f < NUM_FN; f++) begin
      elapsed_d[f] = m6.restart[f] ? '0 : elapsed_inc[f];
    end
  end

  // degrees = adc*500 >> 10, minus offset, clamped to 0..255
  assign scaled  = {adc_value_i, 9'b0} - 19'({adc_value_i, 3'b0}) - 19'({adc_value_i, 2'b0});
  assign deg_raw = scaled[18:10];
  assign deg_off = deg_raw - TEMP_OFFSET;
  assign temp    = (deg_raw < TEMP_OFFSET) ? '0 :
                   (deg_off > TEMP_MAX)    ? '1 : deg_off[TEMP_W-1:0];

  assign take        = is_adc && check_q;
  assign last_sample = (cnt_q == CntW'(SAMPLES_PER_CHECK - 1));
  assign sum_add     = sum_q + SUM_W'(temp);
  // reciprocal multiply, exact for the full sum range
  assign prod        = ProdW'(sum_add) * ProdW'(RecipVal);
  assign avg         = prod[RecipShift +: SUM_W];

  always_comb begin
    mode_d  = (take && last_sample) ? thermostat(m6, avg, cfg_i) : m6;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    check_d = check_q;
    if (is_tick && period_hit) begin
      check_d = 1'b1;
    end
    if (take) begin
      if (last_sample) begin
        sum_d   = '0;
        cnt_d   = '0;
        check_d = 1'b0;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      elapsed_q <= '0;
      mode_q    <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      check_q   <= 1'b0;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      check_q   <= check_d;
    end
  end

  always_comb begin
    res_o.heater_drive   = mode_d.heater_lvl;
    res_o.heater_compare = heat_cmp(mode_d.heater_lvl);
    res_o.fan_drive      = mode_d.fan_lvl;
    res_o.fan_compare    = fan_cmp(mode_d.fan_lvl);
    res_o.heater_lamp    = mode_d.heater_lamp;
    res_o.fan_lamp       = mode_d.fan_lamp;
    res_o.signal_lamp    = mode_d.signal_lamp;
    res_o.check_pending  = check_d;
    res_o.heater_mode    = mode_d.acted[FN_HEATER];
    res_o.fan_mode       = mode_d.acted[FN_FAN];
    res_o.lamp_mode      = mode_d.acted[FN_LAMP][1:0];
  end

  a_check_rise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(check_q) |-> $past(acc_i && is_tick))
    else $error("check raised without a tick");

  a_samples_need_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> check_q)
    else $error("samples held with no check pending");

  a_one_function_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({mode_q.acted[FN_HEATER] != 3'd0, mode_q.acted[FN_LAMP] != 3'd0,
                mode_q.acted[FN_FAN] != 3'd0}) <= 1)
    else $error("more than one function active");

  a_drive_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q.heater_lvl != 2'd0) |-> (mode_q.acted[FN_HEATER] == {1'b0, mode_q.heater_lvl}))
    else $error("heater drive does not follow its mode");

endmodule

// File: rtl/hfmc_obuf.sv
// hfmc_obuf: two-entry output register with skid slot for result transfers.
// Depends on hfmc_pkg.
module hfmc_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hfmc_pkg::res_t  data_i,
  output logic            ready_o,
  output logic            valid_o,
  output hfmc_pkg::res_t  data_o,
  input  logic            ready_i
);
  import hfmc_pkg::*;

  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_load;

  assign out_load = !out_valid_q || ready_i;
  assign ready_o  = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full with output register empty");

endmodule

// File: rtl/heater_fan_mode_controller.sv
// heater_fan_mode_controller: top level; config registers, controller core, output buffer.
// Results are formed combinationally and registered in the output buffer.
// Throughput: one item per cycle if in_ready_o; state update is one pass, input to result.
// A two-entry output buffer keeps accepting while one result waits.
// Reset clears all controller state and loads the configuration defaults; no clearing pass.
module heater_fan_mode_controller #(
  parameter int unsigned SAMPLES_PER_CHECK = 5,
  parameter int unsigned TIME_BITS         = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic                             heater_switch_i,
  input  logic                             lamp_switch_i,
  input  logic                             fan_switch_i,
  input  logic [hfmc_pkg::ADC_W-1:0]       adc_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       heater_drive_o,
  output logic [7:0]                       heater_compare_o,
  output logic [1:0]                       fan_drive_o,
  output logic [4:0]                       fan_compare_o,
  output logic                             heater_lamp_o,
  output logic                             fan_lamp_o,
  output logic                             signal_lamp_o,
  output logic                             check_pending_o,
  output logic [2:0]                       heater_mode_o,
  output logic [2:0]                       fan_mode_o,
  output logic [1:0]                       lamp_mode_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hfmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hfmc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hfmc_pkg::*;

  cfg_t cfg;
  res_t res, res_out;
  logic in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  hfmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  hfmc_core #(
    .SAMPLES_PER_CHECK (SAMPLES_PER_CHECK),
    .TIME_BITS         (TIME_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .op_i            (op_i),
    .heater_switch_i (heater_switch_i),
    .lamp_switch_i   (lamp_switch_i),
    .fan_switch_i    (fan_switch_i),
    .adc_value_i     (adc_value_i),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  hfmc_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .data_o  (res_out),
    .ready_i (out_ready_i)
  );

  assign heater_drive_o   = res_out.heater_drive;
  assign heater_compare_o = res_out.heater_compare;
  assign fan_drive_o      = res_out.fan_drive;
  assign fan_compare_o    = res_out.fan_compare;
  assign heater_lamp_o    = res_out.heater_lamp;
  assign fan_lamp_o       = res_out.fan_lamp;
  assign signal_lamp_o    = res_out.signal_lamp;
  assign check_pending_o  = res_out.check_pending;
  assign heater_mode_o    = res_out.heater_mode;
  assign fan_mode_o       = res_out.fan_mode;
  assign lamp_mode_o      = res_out.lamp_mode;

endmodule

// File: verif/heater_fan_mode_controller_test.sv
// heater_fan_mode_controller_test: self-checking bench for the heater/fan mode controller.
// Directed table then random phases, checked against pinned values or a built-in model.
// Depends on hfmc_pkg and heater_fan_mode_controller.
`timescale 1ns / 100ps

module heater_fan_mode_controller_test;
  import hfmc_pkg::*;

  localparam logic [1:0]      OP_SPARE    = 2'd3;
  localparam int unsigned     NUM_REGS    = 8;
  localparam int unsigned     SAMPLES     = 5;
  localparam int unsigned     PHASES      = 13;
  localparam int unsigned     PHASE_ITEMS = 100;
  localparam int unsigned     QUIET_PHASE = 4;
  localparam logic [3:0][7:0] HEAT_CMP    = {8'd153, 8'd102, 8'd51, 8'd0};
  localparam logic [3:0][4:0] FAN_CMP     = {5'd20, 5'd13, 5'd6, 5'd0};

  typedef struct {
    bit          is_cfg;
    logic [3:0]  idx;
    logic [31:0] data;
    logic [1:0]  op;
    logic [2:0]  lv;     // {heater, lamp, fan}
    logic [9:0]  adc;
    bit          typed;
    res_t        want;
  } plan_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [1:0]  op_i            = 2'd0;
  logic        heater_switch_i = 1'b0;
  logic        lamp_switch_i   = 1'b0;
  logic        fan_switch_i    = 1'b0;
  logic [9:0]  adc_value_i     = 10'd0;
  logic        out_ready_i     = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic [3:0]  cfg_index_i     = 4'd0;
  logic [31:0] cfg_data_i      = 32'd0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        cfg_ready_o;
  logic [1:0]  heater_drive_o;
  logic [7:0]  heater_compare_o;
  logic [1:0]  fan_drive_o;
  logic [4:0]  fan_compare_o;
  logic        heater_lamp_o;
  logic        fan_lamp_o;
  logic        signal_lamp_o;
  logic        check_pending_o;
  logic [2:0]  heater_mode_o;
  logic [2:0]  fan_mode_o;
  logic [1:0]  lamp_mode_o;

  // controller model state
  logic [31:0] ms_now    = 32'd0;
  logic [31:0] phase_cnt = 32'd0;
  logic [31:0] armed_at [NUM_FN];
  logic        sw_last  [NUM_FN];
  logic [2:0]  sw_edges [NUM_FN];
  logic [2:0]  mode_now [NUM_FN];
  logic [1:0]  heat_lvl  = 2'd0;
  logic [1:0]  fan_lvl   = 2'd0;
  logic        heat_lamp = 1'b0;
  logic        fan_lamp  = 1'b0;
  logic        sig_lamp  = 1'b0;
  logic [2:0]  adc_seen  = 3'd0;
  logic [10:0] deg_sum   = 11'd0;
  logic        check_req = 1'b0;

  logic [31:0] heat_tmo  = 32'd50000;
  logic [31:0] fan_tmo   = 32'd30000;
  logic [31:0] lamp_tmo  = 32'd30000;
  logic [31:0] period_ms = 32'd5000;
  logic [7:0]  sp_low    = 8'd30;
  logic [7:0]  sp_mid    = 8'd50;
  logic [7:0]  sp_high   = 8'd70;
  logic [7:0]  crit_deg  = 8'd80;

  res_t        status_q [$];
  bit          pin_on   = 1'b0;
  res_t        pin_res  = '0;
  bit          quiet    = 1'b0;
  bit          cfg_open = 1'b0;

  int unsigned items, acting_items, results, reg_writes, decisions, shutoffs, errors;

  heater_fan_mode_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .heater_switch_i (heater_switch_i),
    .lamp_switch_i   (lamp_switch_i),
    .fan_switch_i    (fan_switch_i),
    .adc_value_i     (adc_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .heater_drive_o  (heater_drive_o),
    .heater_compare_o(heater_compare_o),
    .fan_drive_o     (fan_drive_o),
    .fan_compare_o   (fan_compare_o),
    .heater_lamp_o   (heater_lamp_o),
    .fan_lamp_o      (fan_lamp_o),
    .signal_lamp_o   (signal_lamp_o),
    .check_pending_o (check_pending_o),
    .heater_mode_o   (heater_mode_o),
    .fan_mode_o      (fan_mode_o),
    .lamp_mode_o     (lamp_mode_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 8);
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int exp);
    if (got != exp) begin
      report($sformatf("%s got %0d expected %0d", name, got, exp));
    end
  endtask

  function automatic void drive_fn(int unsigned f, logic [2:0] m);
    logic [1:0] lvl;
    lvl = (m >= 3'd1 && m <= 3'd3) ? m[1:0] : 2'd0;
    if (f == FN_HEATER) begin
      heat_lvl  = lvl;
      heat_lamp = (lvl != 2'd0);
    end else if (f == FN_FAN) begin
      fan_lvl  = lvl;
      fan_lamp = (lvl != 2'd0);
    end else begin
      sig_lamp = (m == 3'd1);
    end
  endfunction

  function automatic void idle_fn(int unsigned f);
    drive_fn(f, 3'd0);
    sw_edges[f] = 3'd0;
    mode_now[f] = 3'd0;
  endfunction

  function automatic void take_switch(int unsigned f, logic lvl);
    if (lvl != sw_last[f]) begin
      sw_last[f]  = lvl;
      sw_edges[f] = sw_edges[f] + 3'd1;
    end
    if (sw_edges[f] > ((f == FN_LAMP) ? 3'd2 : 3'd4)) begin
      sw_edges[f] = 3'd1;
    end
    if (sw_edges[f] != mode_now[f]) begin
      for (int unsigned g = 0; g < NUM_FN; g++) begin
        if (g != f) begin
          idle_fn(g);
        end
      end
      armed_at[f] = ms_now;
      mode_now[f] = sw_edges[f];
      drive_fn(f, mode_now[f]);
    end
  endfunction

  function automatic void enforce_timeout(int unsigned f);
    logic [31:0] lim;
    logic [31:0] spent;
    lim   = (f == FN_HEATER) ? heat_tmo : (f == FN_FAN) ? fan_tmo : lamp_tmo;
    spent = ms_now - armed_at[f];
    if (spent > lim) begin
      if (mode_now[f] != 3'd0) begin
        shutoffs++;
      end
      idle_fn(f);
    end
  endfunction

  function automatic void run_thermostat(int unsigned avg);
    logic [2:0]  m;
    int unsigned sp;
    m  = mode_now[FN_HEATER];
    sp = (m == 3'd1) ? sp_low : (m == 3'd2) ? sp_mid : sp_high;
    drive_fn(FN_HEATER, (avg < crit_deg && m >= 3'd1 && m <= 3'd3 && avg < sp) ? m : 3'd0);
    decisions++;
  endfunction

  function automatic void take_sample(logic [9:0] adc);
    int unsigned deg;
    deg = (32'(adc) * 32'd500) >> 10;
    deg = (deg < 50) ? 0 : deg - 50;
    if (deg > 255) begin
      deg = 255;
    end
    if (!check_req) begin
      return;
    end
    deg_sum = deg_sum + 11'(deg);
    if (adc_seen + 1 >= SAMPLES) begin
      run_thermostat(deg_sum / SAMPLES);
      adc_seen  = 3'd0;
      deg_sum   = 11'd0;
      check_req = 1'b0;
    end else begin
      adc_seen = adc_seen + 3'd1;
    end
  endfunction

  function automatic res_t next_status(logic [1:0] op, logic [2:0] lv, logic [9:0] adc,
                                       output bit acting);
    logic [31:0] nxt;
    logic        lvl [NUM_FN];
    res_t        s;
    lvl[FN_HEATER] = lv[2];
    lvl[FN_LAMP]   = lv[1];
    lvl[FN_FAN]    = lv[0];
    acting = (op == OP_TICK) || (op == OP_SWITCH) || (op == OP_ADC && check_req);
    if (op == OP_TICK) begin
      nxt    = phase_cnt + 32'd1;
      ms_now = ms_now + 32'd1;
      if (nxt >= period_ms) begin
        phase_cnt = 32'd0;
        check_req = 1'b1;
      end else begin
        phase_cnt = nxt;
      end
    end
    for (int unsigned fn = 0; fn < NUM_FN; fn++) begin
      if (op == OP_SWITCH) begin
        take_switch(fn, lvl[fn]);
      end
      enforce_timeout(fn);
    end
    if (op == OP_ADC) begin
      take_sample(adc);
    end
    s.heater_drive   = heat_lvl;
    s.heater_compare = HEAT_CMP[heat_lvl];
    s.fan_drive      = fan_lvl;
    s.fan_compare    = FAN_CMP[fan_lvl];
    s.heater_lamp    = heat_lamp;
    s.fan_lamp       = fan_lamp;
    s.signal_lamp    = sig_lamp;
    s.check_pending  = check_req;
    s.heater_mode    = mode_now[FN_HEATER];
    s.fan_mode       = mode_now[FN_FAN];
    s.lamp_mode      = mode_now[FN_LAMP][1:0];
    return s;
  endfunction

  function automatic void load_reg(logic [3:0] idx, logic [31:0] d);
    case (idx)
      CFG_HEATER_TIMEOUT: heat_tmo  = d;
      CFG_FAN_TIMEOUT:    fan_tmo   = d;
      CFG_LAMP_TIMEOUT:   lamp_tmo  = d;
      CFG_SENSOR_PERIOD:  period_ms = d;
      CFG_SETPOINT_LOW:   sp_low    = d[7:0];
      CFG_SETPOINT_MID:   sp_mid    = d[7:0];
      CFG_SETPOINT_HIGH:  sp_high   = d[7:0];
      CFG_CRITICAL_LIMIT: crit_deg  = d[7:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : watch
    res_t want;
    bit   acting;
    if (cfg_valid_i && cfg_ready_o) begin
      load_reg(cfg_index_i, cfg_data_i);
      reg_writes++;
    end
    if (in_valid_i && in_ready_o) begin
      want = next_status(op_i, {heater_switch_i, lamp_switch_i, fan_switch_i},
                         adc_value_i, acting);
      items++;
      if (acting) begin
        acting_items++;
      end
      status_q.push_back(pin_on ? pin_res : want);
    end
    if (out_valid_o && out_ready_i) begin
      results++;
      if (status_q.size() == 0) begin
        report("result transfer with no prediction waiting");
      end else begin
        want = status_q.pop_front();
        check_field("heater_drive", heater_drive_o, want.heater_drive);
        check_field("heater_compare", heater_compare_o, want.heater_compare);
        check_field("fan_drive", fan_drive_o, want.fan_drive);
        check_field("fan_compare", fan_compare_o, want.fan_compare);
        check_field("heater_lamp", heater_lamp_o, want.heater_lamp);
        check_field("fan_lamp", fan_lamp_o, want.fan_lamp);
        check_field("signal_lamp", signal_lamp_o, want.signal_lamp);
        check_field("check_pending", check_pending_o, want.check_pending);
        check_field("heater_mode", heater_mode_o, want.heater_mode);
        check_field("fan_mode", fan_mode_o, want.fan_mode);
        check_field("lamp_mode", lamp_mode_o, want.lamp_mode);
      end
    end
  end

  // Register writes happen only with the controller drained.
  task automatic write_reg(logic [3:0] idx, logic [31:0] d);
    if (!cfg_open) begin
      in_valid_i <= 1'b0;
      while (status_q.size() != 0) @(negedge clk_i);
      repeat (2) @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_open = 1'b1;
  endtask

  task automatic send_item(logic [1:0] op, logic [2:0] lv, logic [9:0] adc);
    if (cfg_open) begin
      cfg_valid_i <= 1'b0;
      cfg_open = 1'b0;
    end
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    heater_switch_i <= lv[2];
    lamp_switch_i   <= lv[1];
    fan_switch_i    <= lv[0];
    adc_value_i     <= adc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic res_t shown(logic [1:0] hd, logic [7:0] hc, logic [1:0] fd,
                                 logic [4:0] fc, logic hl, logic fl, logic sl, logic cp,
                                 logic [2:0] hm, logic [2:0] fm, logic [1:0] lm);
    res_t s;
    s.heater_drive   = hd;
    s.heater_compare = hc;
    s.fan_drive      = fd;
    s.fan_compare    = fc;
    s.heater_lamp    = hl;
    s.fan_lamp       = fl;
    s.signal_lamp    = sl;
    s.check_pending  = cp;
    s.heater_mode    = hm;
    s.fan_mode       = fm;
    s.lamp_mode      = lm;
    return s;
  endfunction

  function automatic plan_row_t cfg_row(logic [3:0] idx, logic [31:0] d);
    plan_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] op, logic [2:0] lv, logic [9:0] adc);
    plan_row_t r;
    r     = '{default: '0};
    r.op  = op;
    r.lv  = lv;
    r.adc = adc;
    return r;
  endfunction

  function automatic plan_row_t pinned_row(logic [1:0] op, logic [2:0] lv, logic [9:0] adc,
                                           res_t want);
    plan_row_t r;
    r       = item_row(op, lv, adc);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [31:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  initial begin : stimulus
    plan_row_t   plan [$];
    logic [2:0]  lv;
    logic [1:0]  op;
    int unsigned r;
    int unsigned mark;
    logic [31:0] ht, ft, lt, per;
    logic [7:0]  sl, sm, sh, cl;

    foreach (armed_at[f]) begin
      armed_at[f] = 32'd0;
      sw_last[f]  = 1'b0;
      sw_edges[f] = 3'd0;
      mode_now[f] = 3'd0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // heater and fan walk all four modes, lamp wraps after two
    plan.push_back(pinned_row(OP_TICK, 3'b000, 10'd0, shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(1, 51, 0, 0, 1, 0, 0, 0, 1, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b000, 10'd0,
                              shown(2, 102, 0, 0, 1, 0, 0, 0, 2, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(3, 153, 0, 0, 1, 0, 0, 0, 3, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b000, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(1, 51, 0, 0, 1, 0, 0, 0, 1, 0, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b101, 10'd0,
                              shown(0, 0, 1, 6, 0, 1, 0, 0, 0, 1, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(0, 0, 2, 13, 0, 1, 0, 0, 0, 2, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b101, 10'd0,
                              shown(0, 0, 3, 20, 0, 1, 0, 0, 0, 3, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 4, 0)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b110, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b100, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2)));
    plan.push_back(pinned_row(OP_SWITCH, 3'b110, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1)));
    // unused op and a sample with no check pending leave everything alone
    plan.push_back(pinned_row(OP_SPARE, 3'b000, 10'd0,
                              shown(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1)));
    plan.push_back(pinned_row(OP_ADC, 3'b000, 10'd1023,
                              shown(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1)));
    // zero period, short timeouts, critical limit hit, then heater times out
    plan.push_back(cfg_row(CFG_SENSOR_PERIOD, 32'd0));
    plan.push_back(cfg_row(CFG_HEATER_TIMEOUT, 32'd3));
    plan.push_back(cfg_row(CFG_LAMP_TIMEOUT, 32'd2));
    plan.push_back(cfg_row(CFG_FAN_TIMEOUT, 32'd0));
    plan.push_back(cfg_row(CFG_SETPOINT_LOW, 32'd255));
    plan.push_back(cfg_row(CFG_CRITICAL_LIMIT, 32'd90));
    plan.push_back(cfg_row(4'(NUM_REGS + 7), 32'hA5A5_5A5A));
    plan.push_back(item_row(OP_TICK, 3'b111, 10'h3FF));
    plan.push_back(item_row(OP_SWITCH, 3'b010, 10'd0));
    plan.push_back(item_row(OP_ADC, 3'b000, 10'd0));
    plan.push_back(item_row(OP_ADC, 3'b000, 10'd0));
    plan.push_back(item_row(OP_ADC, 3'b000, 10'd100));
    plan.push_back(item_row(OP_ADC, 3'b000, 10'd1023));
    plan.push_back(item_row(OP_ADC, 3'b000, 10'd512));
    repeat (4) plan.push_back(item_row(OP_TICK, 3'b000, 10'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        pin_on  = plan[i].typed;
        pin_res = plan[i].want;
        send_item(plan[i].op, plan[i].lv, plan[i].adc);
      end
    end
    pin_on = 1'b0;

    for (int unsigned p = 0; p < PHASES; p++) begin
      quiet = (p == QUIET_PHASE);
      if (p == 0) begin
        {ht, ft, lt, per} = {4{32'hFFFF_FFFF}};
        {sl, sm, sh, cl}  = {4{8'hFF}};
      end else if (p == 1) begin
        {ht, ft, lt} = '0;
        per          = 32'd1;
        {sl, sm, sh, cl} = '0;
      end else begin
        ht  = pick_timeout();
        ft  = pick_timeout();
        lt  = pick_timeout();
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 10);
        sl  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(0, 60));
        sm  = 8'($urandom_range(20, 100));
        sh  = 8'($urandom_range(40, 140));
        cl  = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(60, 200));
      end
      write_reg(CFG_HEATER_TIMEOUT, ht);
      write_reg(CFG_FAN_TIMEOUT, ft);
      write_reg(CFG_LAMP_TIMEOUT, lt);
      write_reg(CFG_SENSOR_PERIOD, per);
      write_reg(CFG_SETPOINT_LOW, 32'(sl));
      write_reg(CFG_SETPOINT_MID, 32'(sm));
      write_reg(CFG_SETPOINT_HIGH, 32'(sh));
      write_reg(CFG_CRITICAL_LIMIT, 32'(cl));
      write_reg(4'(NUM_REGS + $urandom_range(7)), $urandom);

      lv   = {sw_last[FN_HEATER], sw_last[FN_LAMP], sw_last[FN_FAN]};
      mark = items;
      while (items - mark < PHASE_ITEMS) begin
        r  = $urandom_range(99);
        op = (r < 35) ? OP_TICK : (r < 65) ? OP_SWITCH : (r < 95) ? OP_ADC : OP_SPARE;
        if (op == OP_SWITCH) begin
          // mostly single-switch edges so modes get deep before being cleared
          r = $urandom_range(99);
          if (r < 40) lv[2] = ~lv[2];
          else if (r < 55) lv[1] = ~lv[1];
          else if (r < 75) lv[0] = ~lv[0];
          else if (r < 88) lv = 3'($urandom);
          send_item(op, lv, 10'($urandom));
        end else begin
          send_item(op, 3'($urandom),
                    ($urandom_range(9) < 7) ? 10'($urandom_range(100, 360)) : 10'($urandom));
        end
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    $display("Sent %0d items (%0d acting), compared %0d results, %0d register writes",
             items, acting_items, results, reg_writes);
    $display("Thermostat decisions: %0d, timeout shutoffs: %0d, mismatches: %0d",
             decisions, shutoffs, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
